/* rtl/m65la_pkg.sv */
// Shared types, codes and opcode tables of the 6502 line assembler.
package m65la_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        SY_NONE   = 4'd0,  SY_ACC    = 4'd1,  SY_HASH   = 4'd2,  SY_IMMV   = 4'd3,
        SY_PAREN  = 4'd4,  SY_PVAL   = 4'd5,  SY_PCOMMA = 4'd6,  SY_PX     = 4'd7,
        SY_INDX   = 4'd8,  SY_PCLOSE = 4'd9,  SY_ICOMMA = 4'd10, SY_INDY   = 4'd11,
        SY_VAL    = 4'd12, SY_VCOMMA = 4'd13, SY_VX     = 4'd14, SY_VY     = 4'd15
    } t_syntax;

    typedef enum logic [3:0] {
        M_IMP = 4'd0, M_ACC = 4'd1, M_IMM = 4'd2, M_ZP = 4'd3, M_ZPX = 4'd4,
        M_ZPY = 4'd5, M_ABS = 4'd6, M_ABSX = 4'd7, M_ABSY = 4'd8, M_IND = 4'd9,
        M_ZXI = 4'd10, M_IZY = 4'd11, M_REL = 4'd12, M_NONE = 4'd13
    } t_mode;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001, PH_MNEM = 3'b010, PH_OPER = 3'b100
    } t_phase;

    // One classified line handed from the front end to the back end.
    typedef struct packed {
        logic        blank_line;
        logic        known;
        logic [5:0]  mnem;
        logic        syn_err;
        t_syntax     syntax;
        logic        digit_seen;
        logic [31:0] value;
        logic [15:0] pc;
        logic [1:0]  room;
    } t_line;

    // Mnemonic index 0..63; 63 is ISC and also marks an unknown mnemonic.
    localparam logic [5:0] MN_NONE = 6'd63;

    function automatic logic [5:0] mnem_index(input logic [23:0] m);
        case (m)
            "ADC": return 6'd0;  "AND": return 6'd1;  "CMP": return 6'd2;  "EOR": return 6'd3;
            "LDA": return 6'd4;  "ORA": return 6'd5;  "SBC": return 6'd6;  "STA": return 6'd7;
            "ASL": return 6'd8;  "LSR": return 6'd9;  "ROL": return 6'd10; "ROR": return 6'd11;
            "BIT": return 6'd12; "CPX": return 6'd13; "CPY": return 6'd14; "DEC": return 6'd15;
            "INC": return 6'd16; "LDX": return 6'd17; "LDY": return 6'd18; "STX": return 6'd19;
            "STY": return 6'd20; "JMP": return 6'd21; "JSR": return 6'd22; "BCC": return 6'd23;
            "BCS": return 6'd24; "BEQ": return 6'd25; "BMI": return 6'd26; "BNE": return 6'd27;
            "BPL": return 6'd28; "BVC": return 6'd29; "BVS": return 6'd30; "BRK": return 6'd31;
            "CLC": return 6'd32; "CLD": return 6'd33; "CLI": return 6'd34; "CLV": return 6'd35;
            "SEC": return 6'd36; "SED": return 6'd37; "SEI": return 6'd38; "DEX": return 6'd39;
            "DEY": return 6'd40; "INX": return 6'd41; "INY": return 6'd42; "TAX": return 6'd43;
            "TAY": return 6'd44; "TXA": return 6'd45; "TYA": return 6'd46; "TSX": return 6'd47;
            "TXS": return 6'd48; "PHA": return 6'd49; "PHP": return 6'd50; "PLA": return 6'd51;
            "PLP": return 6'd52; "RTI": return 6'd53; "RTS": return 6'd54; "NOP": return 6'd55;
            "SLO": return 6'd56; "RLA": return 6'd57; "SRE": return 6'd58; "RRA": return 6'd59;
            "SAX": return 6'd60; "LAX": return 6'd61; "DCP": return 6'd62; "ISC": return 6'd63;
            default: return MN_NONE;
        endcase
    endfunction

    // Opcode lookup; bit 8 set means the mode exists for the mnemonic.
    function automatic logic [8:0] rom_find(input logic [5:0] mn, input t_mode md);
        logic [7:0] base;
        base = 8'h00;
        if (mn <= 6'd7) begin
            case (mn)
                6'd0: base = 8'h60; 6'd1: base = 8'h20; 6'd2: base = 8'hC0;
                6'd3: base = 8'h40; 6'd4: base = 8'hA0; 6'd5: base = 8'h00;
                6'd6: base = 8'hE0; default: base = 8'h80;
            endcase
            case (md)
                M_IMM:  return (mn == 6'd7) ? 9'h0 : {1'b1, base | 8'h09};
                M_ZP:   return {1'b1, base | 8'h05};
                M_ZPX:  return {1'b1, base | 8'h15};
                M_ABS:  return {1'b1, base | 8'h0D};
                M_ABSX: return {1'b1, base | 8'h1D};
                M_ABSY: return {1'b1, base | 8'h19};
                M_ZXI:  return {1'b1, base | 8'h01};
                M_IZY:  return {1'b1, base | 8'h11};
                default: return 9'h0;
            endcase
        end
        if (mn >= 6'd8 && mn <= 6'd11) begin
            case (mn)
                6'd8: base = 8'h00; 6'd9: base = 8'h40; 6'd10: base = 8'h20;
                default: base = 8'h60;
            endcase
            case (md)
                M_ACC:  return {1'b1, base | 8'h0A};
                M_ZP:   return {1'b1, base | 8'h06};
                M_ZPX:  return {1'b1, base | 8'h16};
                M_ABS:  return {1'b1, base | 8'h0E};
                M_ABSX: return {1'b1, base | 8'h1E};
                default: return 9'h0;
            endcase
        end
        if (mn >= 6'd56 && mn <= 6'd63 && mn != 6'd60 && mn != 6'd61) begin
            case (mn)
                6'd56: base = 8'h00; 6'd57: base = 8'h20; 6'd58: base = 8'h40;
                6'd59: base = 8'h60; 6'd62: base = 8'hC0; default: base = 8'hE0;
            endcase
            case (md)
                M_ZP:   return {1'b1, base | 8'h07};
                M_ZPX:  return {1'b1, base | 8'h17};
                M_ABS:  return {1'b1, base | 8'h0F};
                M_ABSX: return {1'b1, base | 8'h1F};
                M_ABSY: return {1'b1, base | 8'h1B};
                M_ZXI:  return {1'b1, base | 8'h03};
                M_IZY:  return {1'b1, base | 8'h13};
                default: return 9'h0;
            endcase
        end
        case ({mn, md})
            {6'd12, M_ZP}: return 9'h124;   {6'd12, M_ABS}: return 9'h12C;
            {6'd13, M_IMM}: return 9'h1E0;  {6'd13, M_ZP}: return 9'h1E4;
            {6'd13, M_ABS}: return 9'h1EC;
            {6'd14, M_IMM}: return 9'h1C0;  {6'd14, M_ZP}: return 9'h1C4;
            {6'd14, M_ABS}: return 9'h1CC;
            {6'd15, M_ZP}: return 9'h1C6;   {6'd15, M_ZPX}: return 9'h1D6;
            {6'd15, M_ABS}: return 9'h1CE;  {6'd15, M_ABSX}: return 9'h1DE;
            {6'd16, M_ZP}: return 9'h1E6;   {6'd16, M_ZPX}: return 9'h1F6;
            {6'd16, M_ABS}: return 9'h1EE;  {6'd16, M_ABSX}: return 9'h1FE;
            {6'd17, M_IMM}: return 9'h1A2;  {6'd17, M_ZP}: return 9'h1A6;
            {6'd17, M_ZPY}: return 9'h1B6;  {6'd17, M_ABS}: return 9'h1AE;
            {6'd17, M_ABSY}: return 9'h1BE;
            {6'd18, M_IMM}: return 9'h1A0;  {6'd18, M_ZP}: return 9'h1A4;
            {6'd18, M_ZPX}: return 9'h1B4;  {6'd18, M_ABS}: return 9'h1AC;
            {6'd18, M_ABSX}: return 9'h1BC;
            {6'd19, M_ZP}: return 9'h186;   {6'd19, M_ZPY}: return 9'h196;
            {6'd19, M_ABS}: return 9'h18E;
            {6'd20, M_ZP}: return 9'h184;   {6'd20, M_ZPX}: return 9'h194;
            {6'd20, M_ABS}: return 9'h18C;
            {6'd21, M_ABS}: return 9'h14C;  {6'd21, M_IND}: return 9'h16C;
            {6'd22, M_ABS}: return 9'h120;
            {6'd23, M_REL}: return 9'h190;  {6'd24, M_REL}: return 9'h1B0;
            {6'd25, M_REL}: return 9'h1F0;  {6'd26, M_REL}: return 9'h130;
            {6'd27, M_REL}: return 9'h1D0;  {6'd28, M_REL}: return 9'h110;
            {6'd29, M_REL}: return 9'h150;  {6'd30, M_REL}: return 9'h170;
            {6'd31, M_IMP}: return 9'h100;  {6'd32, M_IMP}: return 9'h118;
            {6'd33, M_IMP}: return 9'h1D8;  {6'd34, M_IMP}: return 9'h158;
            {6'd35, M_IMP}: return 9'h1B8;  {6'd36, M_IMP}: return 9'h138;
            {6'd37, M_IMP}: return 9'h1F8;  {6'd38, M_IMP}: return 9'h178;
            {6'd39, M_IMP}: return 9'h1CA;  {6'd40, M_IMP}: return 9'h188;
            {6'd41, M_IMP}: return 9'h1E8;  {6'd42, M_IMP}: return 9'h1C8;
            {6'd43, M_IMP}: return 9'h1AA;  {6'd44, M_IMP}: return 9'h1A8;
            {6'd45, M_IMP}: return 9'h18A;  {6'd46, M_IMP}: return 9'h198;
            {6'd47, M_IMP}: return 9'h1BA;  {6'd48, M_IMP}: return 9'h19A;
            {6'd49, M_IMP}: return 9'h148;  {6'd50, M_IMP}: return 9'h108;
            {6'd51, M_IMP}: return 9'h168;  {6'd52, M_IMP}: return 9'h128;
            {6'd53, M_IMP}: return 9'h140;  {6'd54, M_IMP}: return 9'h160;
            {6'd55, M_IMP}: return 9'h1EA;
            {6'd60, M_ZP}: return 9'h187;   {6'd60, M_ZPY}: return 9'h197;
            {6'd60, M_ABS}: return 9'h18F;  {6'd60, M_ZXI}: return 9'h183;
            {6'd61, M_ZP}: return 9'h1A7;   {6'd61, M_ZPY}: return 9'h1B7;
            {6'd61, M_ABS}: return 9'h1AF;  {6'd61, M_ABSY}: return 9'h1BF;
            {6'd61, M_ZXI}: return 9'h1A3;  {6'd61, M_IZY}: return 9'h1B3;
            default: return 9'h0;
        endcase
    endfunction

    function automatic logic [1:0] mode_size(input t_mode md);
        case (md)
            M_IMP, M_ACC: return 2'd1;
            M_ABS, M_ABSX, M_ABSY, M_IND: return 2'd3;
            default: return 2'd2;
        endcase
    endfunction

endpackage

/* rtl/m65la_front.sv */
// Front end: trims, folds case and classifies a line one character per cycle while i_valid is high.
module m65la_front import m65la_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    input  logic [15:0] i_pc,
    input  logic [1:0]  i_room,
    output logic        o_line_valid,
    output t_line       o_line
);

    t_phase      r_phase, n_phase;
    logic [23:0] r_mn, n_mn;
    logic [2:0]  r_mlen, n_mlen;
    t_syntax     r_syn, n_syn;
    logic [31:0] r_val, n_val;
    logic        r_hex, n_hex, r_dig, n_dig, r_trail, n_trail, r_err, n_err;

    logic [7:0]  c;
    logic        blank;
    logic        d_ok;
    logic [3:0]  d_val;
    logic        hex_use;
    logic [31:0] val_fed;

    always_comb begin
        c = (i_ch inside {[8'h61:8'h7A]}) ? i_ch - 8'd32 : i_ch;
        blank = (c == 8'h20) || (c == 8'h09);
    end

    // Starting a value clears the hex flag and value first.
    always_comb begin
        logic        start;
        logic [31:0] base;
        start = (r_syn == SY_NONE) || (r_syn == SY_HASH) || (r_syn == SY_PAREN);
        hex_use = start ? 1'b0 : r_hex;
        base = start ? 32'd0 : r_val;
        d_ok = 1'b0;
        d_val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d_ok = 1'b1;
            d_val = c[3:0];
        end else if (hex_use && (c inside {[8'h41:8'h46]})) begin
            d_ok = 1'b1;
            d_val = c[3:0] + 4'd9;
        end
        val_fed = (hex_use ? (base << 4) : ((base << 3) + (base << 1)))
                + {28'd0, d_val};
    end

    always_comb begin
        logic ok;
        t_syntax nx;
        t_phase ph;
        n_phase = r_phase; n_mn = r_mn; n_mlen = r_mlen; n_syn = r_syn;
        n_val = r_val; n_hex = r_hex; n_dig = r_dig; n_trail = r_trail; n_err = r_err;
        ok = 1'b1;
        nx = r_syn;
        ph = r_phase;
        if (ph == PH_LEAD && !blank) ph = PH_MNEM;
        n_phase = ph;
        if (ph == PH_MNEM) begin
            if (blank) begin
                n_phase = PH_OPER;
            end else begin
                case (r_mlen)
                    3'd0: n_mn[23:16] = c;
                    3'd1: n_mn[15:8] = c;
                    3'd2: n_mn[7:0] = c;
                    default: ;
                endcase
                if (r_mlen < 3'd4) n_mlen = r_mlen + 3'd1;
            end
        end else if (ph == PH_OPER) begin
            if (blank) begin
                if (r_syn != SY_NONE) n_trail = 1'b1;
            end else if (!r_err) begin
                if (r_trail) begin
                    n_err = 1'b1;
                end else begin
                    case (r_syn)
                        SY_NONE: begin
                            if (c == "A") nx = SY_ACC;
                            else if (c == "#") nx = SY_HASH;
                            else if (c == "(") nx = SY_PAREN;
                            else begin
                                n_val = 32'd0; n_hex = 1'b0; n_dig = 1'b0;
                                if (c == "$") begin
                                    n_hex = 1'b1; nx = SY_VAL;
                                end else if (d_ok) begin
                                    n_val = val_fed; n_dig = 1'b1; nx = SY_VAL;
                                end else ok = 1'b0;
                            end
                        end
                        SY_HASH, SY_PAREN: begin
                            nx = (r_syn == SY_HASH) ? SY_IMMV : SY_PVAL;
                            n_val = 32'd0; n_hex = 1'b0; n_dig = 1'b0;
                            if (c == "$") n_hex = 1'b1;
                            else if (d_ok) begin
                                n_val = val_fed; n_dig = 1'b1;
                            end else ok = 1'b0;
                        end
                        SY_IMMV, SY_PVAL, SY_VAL: begin
                            if (c == "," && r_dig && r_syn != SY_IMMV)
                                nx = (r_syn == SY_PVAL) ? SY_PCOMMA : SY_VCOMMA;
                            else if (c == ")" && r_dig && r_syn == SY_PVAL)
                                nx = SY_PCLOSE;
                            else if (d_ok) begin
                                n_val = val_fed; n_dig = 1'b1;
                            end else ok = 1'b0;
                        end
                        SY_PCOMMA: begin ok = (c == "X"); nx = SY_PX; end
                        SY_PX:     begin ok = (c == ")"); nx = SY_INDX; end
                        SY_PCLOSE: begin ok = (c == ","); nx = SY_ICOMMA; end
                        SY_ICOMMA: begin ok = (c == "Y"); nx = SY_INDY; end
                        SY_VCOMMA: begin
                            if (c == "X") nx = SY_VX;
                            else if (c == "Y") nx = SY_VY;
                            else ok = 1'b0;
                        end
                        default: ok = 1'b0;
                    endcase
                    if (ok) n_syn = nx;
                    else n_err = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_line.blank_line = (n_phase == PH_LEAD);
        o_line.mnem       = mnem_index(n_mn);
        o_line.known      = (n_mlen == 3'd3) && (mnem_index(n_mn) != MN_NONE
                            || n_mn == "ISC");
        o_line.syn_err    = n_err;
        o_line.syntax     = n_syn;
        o_line.digit_seen = n_dig;
        o_line.value      = n_val;
        o_line.pc         = i_pc;
        o_line.room       = i_room;
        o_line_valid      = i_valid && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_phase <= PH_LEAD; r_mn <= 24'd0; r_mlen <= 3'd0; r_syn <= SY_NONE;
            r_val <= 32'd0; r_hex <= 1'b0; r_dig <= 1'b0; r_trail <= 1'b0; r_err <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_mn <= n_mn; r_mlen <= n_mlen; r_syn <= n_syn;
            r_val <= n_val; r_hex <= n_hex; r_dig <= n_dig; r_trail <= n_trail;
            r_err <= n_err;
        end
    end

endmodule

/* rtl/m65la_queue.sv */
// Small queue of classified lines between the front and back ends.
module m65la_queue import m65la_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_line i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_line o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_line         r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full)
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop && !o_empty)
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

endmodule

/* rtl/m65la_back.sv */
// Back end: picks the addressing mode and builds the instruction bytes.
module m65la_back import m65la_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_line       i_line,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_status,
    output logic [1:0]  o_length,
    output logic [7:0]  o_byte0,
    output logic [7:0]  o_byte1,
    output logic [7:0]  o_byte2
);

    logic        r_valid;
    logic [1:0]  r_status, r_length;
    logic [7:0]  r_b0, r_b1, r_b2;
    logic [1:0]  n_status, n_length;
    logic [7:0]  n_b0, n_b1, n_b2;

    logic load;
    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;

    always_comb begin
        t_mode       md;
        logic        zp_val;
        logic [8:0]  hit;
        logic [8:0]  f_zp, f_zpx, f_zpy, f_rel, f_acc, f_imp;
        logic [16:0] tgt;
        logic [32:0] off;
        logic [5:0]  mn;
        mn = i_line.mnem;
        zp_val = (i_line.value[31:8] == 24'd0);
        f_zp  = rom_find(mn, M_ZP);
        f_zpx = rom_find(mn, M_ZPX);
        f_zpy = rom_find(mn, M_ZPY);
        f_rel = rom_find(mn, M_REL);
        f_acc = rom_find(mn, M_ACC);
        f_imp = rom_find(mn, M_IMP);
        md = M_NONE;
        case (i_line.syntax)
            SY_NONE:   md = M_IMP;
            SY_ACC:    md = M_ACC;
            SY_IMMV:   md = i_line.digit_seen ? M_IMM : M_NONE;
            SY_INDX:   md = M_ZXI;
            SY_INDY:   md = M_IZY;
            SY_PCLOSE: md = M_IND;
            SY_VX:     md = (zp_val && f_zpx[8]) ? M_ZPX : M_ABSX;
            SY_VY:     md = (zp_val && f_zpy[8]) ? M_ZPY : M_ABSY;
            SY_VAL: begin
                if (!i_line.digit_seen) md = M_NONE;
                else if (f_rel[8]) md = M_REL;
                else md = (zp_val && f_zp[8]) ? M_ZP : M_ABS;
            end
            default: md = M_NONE;
        endcase
        if (md == M_IMP && f_acc[8] && !f_imp[8]) md = M_ACC;
        hit = (md == M_NONE) ? 9'h0 : rom_find(mn, md);
        if (md != M_NONE && !hit[8]) begin
            case (md)
                M_ZP:  md = M_ABS;
                M_ZPX: md = M_ABSX;
                M_ZPY: md = M_ABSY;
                default: md = M_NONE;
            endcase
            hit = (md == M_NONE) ? 9'h0 : rom_find(mn, md);
        end
        tgt = {1'b0, i_line.pc} + 17'd2;
        off = {i_line.value[31], i_line.value} - {16'd0, tgt};
        n_status = ST_ERR; n_length = 2'd0; n_b0 = 8'd0; n_b1 = 8'd0; n_b2 = 8'd0;
        if (i_line.blank_line) begin
            n_status = ST_EMPTY;
        end else if (i_line.known && !i_line.syn_err && hit[8]
                     && mode_size(md) <= i_line.room) begin
            if (md == M_REL) begin
                // Offset fits a signed byte when bits 32..7 all agree.
                if (off[32:7] == '0 || off[32:7] == '1) begin
                    n_status = ST_OK; n_length = 2'd2; n_b0 = hit[7:0]; n_b1 = off[7:0];
                end
            end else begin
                n_status = ST_OK;
                n_length = mode_size(md);
                n_b0 = hit[7:0];
                if (mode_size(md) > 2'd1) n_b1 = i_line.value[7:0];
                if (mode_size(md) > 2'd2) n_b2 = i_line.value[15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (load) r_valid <= 1'b1;
        else if (i_pop) r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status; r_length <= n_length;
            r_b0 <= n_b0; r_b1 <= n_b1; r_b2 <= n_b2;
        end
    end

    assign o_empty  = !r_valid;
    assign o_status = r_status;
    assign o_length = r_length;
    assign o_byte0  = r_b0;
    assign o_byte1  = r_b1;
    assign o_byte2  = r_b2;

endmodule

/* rtl/mos6502_line_assembler_top.sv */
// One-line 6502 assembler fed one character per cycle while full is low.
// Throughput: one character per cycle while full is low; the front end steps its parser on every accepted push.
// A finished line passes through the line queue, then through the opcode lookup into
//   the result register.
// full is the line queue's full flag, which rises only while the result register is held as well.
// Reset (synchronous, active low) clears the parser, the queue and the result.
module mos6502_line_assembler_top import m65la_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    input  logic [15:0] i_pc,
    input  logic [1:0]  i_room,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [1:0]  o_length,
    output logic [7:0]  o_byte0,
    output logic [7:0]  o_byte1,
    output logic [7:0]  o_byte2
);

    logic  line_valid, q_full, q_empty, q_pop;
    t_line line_in, line_out;

    assign full = q_full;

    m65la_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(push && !q_full), .i_ch, .i_last, .i_pc, .i_room,
        .o_line_valid(line_valid), .o_line(line_in)
    );

    m65la_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(line_valid), .i_data(line_in), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(line_out)
    );

    m65la_back u_back (
        .i_clk, .i_rst_n,
        .i_q_empty(q_empty), .i_line(line_out), .o_q_pop(q_pop),
        .o_empty(empty), .i_pop(pop),
        .o_status, .o_length, .o_byte0, .o_byte1, .o_byte2
    );

endmodule

/* bench/mos6502_line_assembler_checker.sv */
`timescale 1ns / 100ps
// Line assembler scoreboard: predicts each assembled line and checks the result queue.
module mos6502_line_assembler_checker import m65la_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    input  logic [15:0] i_pc,
    input  logic [1:0]  i_room,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  o_status,
    input  logic [1:0]  o_length,
    input  logic [7:0]  o_byte0,
    input  logic [7:0]  o_byte1,
    input  logic [7:0]  o_byte2,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] length;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_asm_result;

    t_asm_result expected_lines[$];

    logic [7:0]  mn_chars [3];
    logic [2:0]  mn_len;
    t_phase      phase;
    t_syntax     syntax;
    logic [31:0] value;
    logic        hex_mode;
    logic        have_digit;
    logic        trail_blank;
    logic        syn_err;

    // Bit 8 set when the mnemonic has the mode.
    function automatic logic [8:0] opcode_of(input logic [23:0] mn, input t_mode md);
        case ({mn, md})
            {"ADC",M_IMM}: return 9'h169; {"ADC",M_ZP}: return 9'h165; {"ADC",M_ZPX}: return 9'h175;
            {"ADC",M_ABS}: return 9'h16D; {"ADC",M_ABSX}: return 9'h17D; {"ADC",M_ABSY}: return 9'h179;
            {"ADC",M_ZXI}: return 9'h161; {"ADC",M_IZY}: return 9'h171;
            {"AND",M_IMM}: return 9'h129; {"AND",M_ZP}: return 9'h125; {"AND",M_ZPX}: return 9'h135;
            {"AND",M_ABS}: return 9'h12D; {"AND",M_ABSX}: return 9'h13D; {"AND",M_ABSY}: return 9'h139;
            {"AND",M_ZXI}: return 9'h121; {"AND",M_IZY}: return 9'h131;
            {"CMP",M_IMM}: return 9'h1C9; {"CMP",M_ZP}: return 9'h1C5; {"CMP",M_ZPX}: return 9'h1D5;
            {"CMP",M_ABS}: return 9'h1CD; {"CMP",M_ABSX}: return 9'h1DD; {"CMP",M_ABSY}: return 9'h1D9;
            {"CMP",M_ZXI}: return 9'h1C1; {"CMP",M_IZY}: return 9'h1D1;
            {"EOR",M_IMM}: return 9'h149; {"EOR",M_ZP}: return 9'h145; {"EOR",M_ZPX}: return 9'h155;
            {"EOR",M_ABS}: return 9'h14D; {"EOR",M_ABSX}: return 9'h15D; {"EOR",M_ABSY}: return 9'h159;
            {"EOR",M_ZXI}: return 9'h141; {"EOR",M_IZY}: return 9'h151;
            {"LDA",M_IMM}: return 9'h1A9; {"LDA",M_ZP}: return 9'h1A5; {"LDA",M_ZPX}: return 9'h1B5;
            {"LDA",M_ABS}: return 9'h1AD; {"LDA",M_ABSX}: return 9'h1BD; {"LDA",M_ABSY}: return 9'h1B9;
            {"LDA",M_ZXI}: return 9'h1A1; {"LDA",M_IZY}: return 9'h1B1;
            {"ORA",M_IMM}: return 9'h109; {"ORA",M_ZP}: return 9'h105; {"ORA",M_ZPX}: return 9'h115;
            {"ORA",M_ABS}: return 9'h10D; {"ORA",M_ABSX}: return 9'h11D; {"ORA",M_ABSY}: return 9'h119;
            {"ORA",M_ZXI}: return 9'h101; {"ORA",M_IZY}: return 9'h111;
            {"SBC",M_IMM}: return 9'h1E9; {"SBC",M_ZP}: return 9'h1E5; {"SBC",M_ZPX}: return 9'h1F5;
            {"SBC",M_ABS}: return 9'h1ED; {"SBC",M_ABSX}: return 9'h1FD; {"SBC",M_ABSY}: return 9'h1F9;
            {"SBC",M_ZXI}: return 9'h1E1; {"SBC",M_IZY}: return 9'h1F1;
            {"STA",M_ZP}: return 9'h185; {"STA",M_ZPX}: return 9'h195; {"STA",M_ABS}: return 9'h18D;
            {"STA",M_ABSX}: return 9'h19D; {"STA",M_ABSY}: return 9'h199; {"STA",M_ZXI}: return 9'h181;
            {"STA",M_IZY}: return 9'h191;
            {"ASL",M_ACC}: return 9'h10A; {"ASL",M_ZP}: return 9'h106; {"ASL",M_ZPX}: return 9'h116;
            {"ASL",M_ABS}: return 9'h10E; {"ASL",M_ABSX}: return 9'h11E;
            {"LSR",M_ACC}: return 9'h14A; {"LSR",M_ZP}: return 9'h146; {"LSR",M_ZPX}: return 9'h156;
            {"LSR",M_ABS}: return 9'h14E; {"LSR",M_ABSX}: return 9'h15E;
            {"ROL",M_ACC}: return 9'h12A; {"ROL",M_ZP}: return 9'h126; {"ROL",M_ZPX}: return 9'h136;
            {"ROL",M_ABS}: return 9'h12E; {"ROL",M_ABSX}: return 9'h13E;
            {"ROR",M_ACC}: return 9'h16A; {"ROR",M_ZP}: return 9'h166; {"ROR",M_ZPX}: return 9'h176;
            {"ROR",M_ABS}: return 9'h16E; {"ROR",M_ABSX}: return 9'h17E;
            {"BIT",M_ZP}: return 9'h124; {"BIT",M_ABS}: return 9'h12C;
            {"CPX",M_IMM}: return 9'h1E0; {"CPX",M_ZP}: return 9'h1E4; {"CPX",M_ABS}: return 9'h1EC;
            {"CPY",M_IMM}: return 9'h1C0; {"CPY",M_ZP}: return 9'h1C4; {"CPY",M_ABS}: return 9'h1CC;
            {"DEC",M_ZP}: return 9'h1C6; {"DEC",M_ZPX}: return 9'h1D6; {"DEC",M_ABS}: return 9'h1CE;
            {"DEC",M_ABSX}: return 9'h1DE;
            {"INC",M_ZP}: return 9'h1E6; {"INC",M_ZPX}: return 9'h1F6; {"INC",M_ABS}: return 9'h1EE;
            {"INC",M_ABSX}: return 9'h1FE;
            {"LDX",M_IMM}: return 9'h1A2; {"LDX",M_ZP}: return 9'h1A6; {"LDX",M_ZPY}: return 9'h1B6;
            {"LDX",M_ABS}: return 9'h1AE; {"LDX",M_ABSY}: return 9'h1BE;
            {"LDY",M_IMM}: return 9'h1A0; {"LDY",M_ZP}: return 9'h1A4; {"LDY",M_ZPX}: return 9'h1B4;
            {"LDY",M_ABS}: return 9'h1AC; {"LDY",M_ABSX}: return 9'h1BC;
            {"STX",M_ZP}: return 9'h186; {"STX",M_ZPY}: return 9'h196; {"STX",M_ABS}: return 9'h18E;
            {"STY",M_ZP}: return 9'h184; {"STY",M_ZPX}: return 9'h194; {"STY",M_ABS}: return 9'h18C;
            {"JMP",M_ABS}: return 9'h14C; {"JMP",M_IND}: return 9'h16C; {"JSR",M_ABS}: return 9'h120;
            {"BCC",M_REL}: return 9'h190; {"BCS",M_REL}: return 9'h1B0; {"BEQ",M_REL}: return 9'h1F0;
            {"BMI",M_REL}: return 9'h130; {"BNE",M_REL}: return 9'h1D0; {"BPL",M_REL}: return 9'h110;
            {"BVC",M_REL}: return 9'h150; {"BVS",M_REL}: return 9'h170;
            {"BRK",M_IMP}: return 9'h100; {"CLC",M_IMP}: return 9'h118; {"CLD",M_IMP}: return 9'h1D8;
            {"CLI",M_IMP}: return 9'h158; {"CLV",M_IMP}: return 9'h1B8; {"SEC",M_IMP}: return 9'h138;
            {"SED",M_IMP}: return 9'h1F8; {"SEI",M_IMP}: return 9'h178; {"DEX",M_IMP}: return 9'h1CA;
            {"DEY",M_IMP}: return 9'h188; {"INX",M_IMP}: return 9'h1E8; {"INY",M_IMP}: return 9'h1C8;
            {"TAX",M_IMP}: return 9'h1AA; {"TAY",M_IMP}: return 9'h1A8; {"TXA",M_IMP}: return 9'h18A;
            {"TYA",M_IMP}: return 9'h198; {"TSX",M_IMP}: return 9'h1BA; {"TXS",M_IMP}: return 9'h19A;
            {"PHA",M_IMP}: return 9'h148; {"PHP",M_IMP}: return 9'h108; {"PLA",M_IMP}: return 9'h168;
            {"PLP",M_IMP}: return 9'h128; {"RTI",M_IMP}: return 9'h140; {"RTS",M_IMP}: return 9'h160;
            {"NOP",M_IMP}: return 9'h1EA;
            {"SLO",M_ZP}: return 9'h107; {"SLO",M_ZPX}: return 9'h117; {"SLO",M_ABS}: return 9'h10F;
            {"SLO",M_ABSX}: return 9'h11F; {"SLO",M_ABSY}: return 9'h11B; {"SLO",M_ZXI}: return 9'h103;
            {"SLO",M_IZY}: return 9'h113;
            {"RLA",M_ZP}: return 9'h127; {"RLA",M_ZPX}: return 9'h137; {"RLA",M_ABS}: return 9'h12F;
            {"RLA",M_ABSX}: return 9'h13F; {"RLA",M_ABSY}: return 9'h13B; {"RLA",M_ZXI}: return 9'h123;
            {"RLA",M_IZY}: return 9'h133;
            {"SRE",M_ZP}: return 9'h147; {"SRE",M_ZPX}: return 9'h157; {"SRE",M_ABS}: return 9'h14F;
            {"SRE",M_ABSX}: return 9'h15F; {"SRE",M_ABSY}: return 9'h15B; {"SRE",M_ZXI}: return 9'h143;
            {"SRE",M_IZY}: return 9'h153;
            {"RRA",M_ZP}: return 9'h167; {"RRA",M_ZPX}: return 9'h177; {"RRA",M_ABS}: return 9'h16F;
            {"RRA",M_ABSX}: return 9'h17F; {"RRA",M_ABSY}: return 9'h17B; {"RRA",M_ZXI}: return 9'h163;
            {"RRA",M_IZY}: return 9'h173;
            {"SAX",M_ZP}: return 9'h187; {"SAX",M_ZPY}: return 9'h197; {"SAX",M_ABS}: return 9'h18F;
            {"SAX",M_ZXI}: return 9'h183;
            {"LAX",M_ZP}: return 9'h1A7; {"LAX",M_ZPY}: return 9'h1B7; {"LAX",M_ABS}: return 9'h1AF;
            {"LAX",M_ABSY}: return 9'h1BF; {"LAX",M_ZXI}: return 9'h1A3; {"LAX",M_IZY}: return 9'h1B3;
            {"DCP",M_ZP}: return 9'h1C7; {"DCP",M_ZPX}: return 9'h1D7; {"DCP",M_ABS}: return 9'h1CF;
            {"DCP",M_ABSX}: return 9'h1DF; {"DCP",M_ABSY}: return 9'h1DB; {"DCP",M_ZXI}: return 9'h1C3;
            {"DCP",M_IZY}: return 9'h1D3;
            {"ISC",M_ZP}: return 9'h1E7; {"ISC",M_ZPX}: return 9'h1F7; {"ISC",M_ABS}: return 9'h1EF;
            {"ISC",M_ABSX}: return 9'h1FF; {"ISC",M_ABSY}: return 9'h1FB; {"ISC",M_ZXI}: return 9'h1E3;
            {"ISC",M_IZY}: return 9'h1F3;
            default: return 9'h000;
        endcase
    endfunction

    function automatic logic [1:0] instr_size(input t_mode md);
        case (md)
            M_IMP, M_ACC: return 2'd1;
            M_ABS, M_ABSX, M_ABSY, M_IND: return 2'd3;
            default: return 2'd2;
        endcase
    endfunction

    function automatic logic has_mode(input t_mode md);
        logic [8:0] op;
        op = opcode_of({mn_chars[0], mn_chars[1], mn_chars[2]}, md);
        return op[8];
    endfunction

    function automatic logic known_mnemonic();
        logic hit;
        hit = 1'b0;
        for (int m = 0; m <= int'(M_REL); m++)
            if (has_mode(t_mode'(m))) hit = 1'b1;
        return hit && mn_len == 3'd3;
    endfunction

    function automatic logic feed_digit(input logic [7:0] c);
        logic [3:0] d;
        if (c >= "0" && c <= "9") d = 4'(c - "0");
        else if (hex_mode && c >= "A" && c <= "F") d = 4'(c - "A" + 10);
        else return 1'b0;
        value = value * (hex_mode ? 32'd16 : 32'd10) + 32'(d);
        have_digit = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic start_value(input logic [7:0] c);
        value = '0;
        have_digit = 1'b0;
        hex_mode = 1'b0;
        if (c == "$") begin
            hex_mode = 1'b1;
            return 1'b1;
        end
        return feed_digit(c);
    endfunction

    function automatic void operand_char(input logic [7:0] c);
        t_syntax nx;
        logic ok;
        nx = syntax;
        ok = 1'b1;
        case (syntax)
            SY_NONE: begin
                if (c == "A") nx = SY_ACC;
                else if (c == "#") nx = SY_HASH;
                else if (c == "(") nx = SY_PAREN;
                else if (start_value(c)) nx = SY_VAL;
                else ok = 1'b0;
            end
            SY_HASH: begin
                ok = start_value(c);
                nx = SY_IMMV;
            end
            SY_IMMV: ok = feed_digit(c);
            SY_PAREN: begin
                ok = start_value(c);
                nx = SY_PVAL;
            end
            SY_PVAL: begin
                if (c == "," && have_digit) nx = SY_PCOMMA;
                else if (c == ")" && have_digit) nx = SY_PCLOSE;
                else ok = feed_digit(c);
            end
            SY_PCOMMA: begin
                ok = (c == "X");
                nx = SY_PX;
            end
            SY_PX: begin
                ok = (c == ")");
                nx = SY_INDX;
            end
            SY_PCLOSE: begin
                ok = (c == ",");
                nx = SY_ICOMMA;
            end
            SY_ICOMMA: begin
                ok = (c == "Y");
                nx = SY_INDY;
            end
            SY_VAL: begin
                if (c == "," && have_digit) nx = SY_VCOMMA;
                else ok = feed_digit(c);
            end
            SY_VCOMMA: begin
                if (c == "X") nx = SY_VX;
                else if (c == "Y") nx = SY_VY;
                else ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase
        if (ok) syntax = nx;
        else syn_err = 1'b1;
    endfunction

    // Returns M_NONE where the operand form gives no mode.
    function automatic t_mode operand_mode();
        logic small_val;
        small_val = (value <= 32'hFF);
        case (syntax)
            SY_NONE:   return M_IMP;
            SY_ACC:    return M_ACC;
            SY_IMMV:   return have_digit ? M_IMM : M_NONE;
            SY_INDX:   return M_ZXI;
            SY_INDY:   return M_IZY;
            SY_PCLOSE: return M_IND;
            SY_VX:     return (small_val && has_mode(M_ZPX)) ? M_ZPX : M_ABSX;
            SY_VY:     return (small_val && has_mode(M_ZPY)) ? M_ZPY : M_ABSY;
            SY_VAL: begin
                if (!have_digit) return M_NONE;
                if (has_mode(M_REL)) return M_REL;
                return (small_val && has_mode(M_ZP)) ? M_ZP : M_ABS;
            end
            default:   return M_NONE;
        endcase
    endfunction

    function automatic void clear_line();
        mn_chars = '{8'h00, 8'h00, 8'h00};
        mn_len = '0;
        phase = PH_LEAD;
        syntax = SY_NONE;
        value = '0;
        hex_mode = 1'b0;
        have_digit = 1'b0;
        trail_blank = 1'b0;
        syn_err = 1'b0;
    endfunction

    function automatic void assemble_char(input logic [7:0] ch_in, input logic fin,
                                          input logic [15:0] pc_in, input logic [1:0] room_in);
        logic [7:0]  c;
        logic        blank;
        t_mode       md;
        logic [8:0]  op;
        longint      offset;
        t_asm_result r;
        c = (ch_in >= "a" && ch_in <= "z") ? ch_in - 8'd32 : ch_in;
        blank = (c == " " || c == 8'h09);
        if (phase == PH_LEAD && !blank) phase = PH_MNEM;
        if (phase == PH_MNEM) begin
            if (blank) begin
                phase = PH_OPER;
            end else begin
                if (mn_len < 3'd3) mn_chars[mn_len] = c;
                if (mn_len < 3'd4) mn_len = mn_len + 3'd1;
            end
        end else if (phase == PH_OPER) begin
            if (blank) begin
                if (syntax != SY_NONE) trail_blank = 1'b1;
            end else if (!syn_err) begin
                if (trail_blank) syn_err = 1'b1;
                else operand_char(c);
            end
        end
        if (!fin) return;

        r = '{status: ST_ERR, default: '0};
        if (phase == PH_LEAD) begin
            r.status = ST_EMPTY;
        end else if (known_mnemonic() && !syn_err) begin
            md = operand_mode();
            op = 9'h000;
            // shift-only mnemonics take a bare line as accumulator
            if (md == M_IMP && has_mode(M_ACC) && !has_mode(M_IMP)) md = M_ACC;
            if (md != M_NONE) begin
                op = opcode_of({mn_chars[0], mn_chars[1], mn_chars[2]}, md);
                if (!op[8]) begin
                    case (md)
                        M_ZP:    md = M_ABS;
                        M_ZPX:   md = M_ABSX;
                        M_ZPY:   md = M_ABSY;
                        default: md = M_NONE;
                    endcase
                    if (md != M_NONE) op = opcode_of({mn_chars[0], mn_chars[1], mn_chars[2]}, md);
                end
            end
            if (md != M_NONE && op[8] && instr_size(md) <= room_in) begin
                if (md == M_REL) begin
                    offset = longint'($signed(value)) - (longint'(pc_in) + 2);
                    if (offset >= -128 && offset <= 127) begin
                        r = '{ST_OK, 2'd2, op[7:0], 8'(offset), 8'h00};
                    end
                end else begin
                    r.status = ST_OK;
                    r.length = instr_size(md);
                    r.b0 = op[7:0];
                    if (r.length > 2'd1) r.b1 = value[7:0];
                    if (r.length > 2'd2) r.b2 = value[15:8];
                end
            end
        end
        expected_lines.push_back(r);
        clear_line();
    endfunction

    initial begin
        clear_line();
    end

    always @(posedge i_clk) begin
        t_asm_result want;
        t_asm_result got;
        if (i_rst_n) begin
            if (push && !full) assemble_char(i_ch, i_last, i_pc, i_room);
            if (pop && !empty) begin
                got = '{o_status, o_length, o_byte0, o_byte1, o_byte2};
                if (expected_lines.size() == 0) begin
                    $display("%0t: result with none expected: %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_lines.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch status/len/b0/b1/b2 exp %0d %0d %h %h %h act %0d %0d %h %h %h",
                                 $time, want.status, want.length, want.b0, want.b1, want.b2,
                                 got.status, got.length, got.b0, got.b1, got.b2);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_lines.size();
    end

endmodule

/* bench/mos6502_line_assembler_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the 6502 line assembler: line stimulus, result drain and verdict.
module mos6502_line_assembler_top_tb;
    import m65la_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_ch = '0;
    logic        i_last = 1'b0;
    logic [15:0] i_pc = '0;
    logic [1:0]  i_room = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [1:0]  o_length;
    logic [7:0]  o_byte0;
    logic [7:0]  o_byte1;
    logic [7:0]  o_byte2;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    int          chars_sent = 0;
    bit          burst_mode = 0;
    byte unsigned line_chars[$];

    string mnem_pool[] = '{
        "ADC","AND","CMP","EOR","LDA","ORA","SBC","STA","ASL","LSR","ROL","ROR","BIT","CPX",
        "CPY","DEC","INC","LDX","LDY","STX","STY","JMP","JSR","BCC","BCS","BEQ","BMI","BNE",
        "BPL","BVC","BVS","BRK","CLC","CLD","CLI","CLV","SEC","SED","SEI","DEX","DEY","INX",
        "INY","TAX","TAY","TXA","TYA","TSX","TXS","PHA","PHP","PLA","PLP","RTI","RTS","NOP",
        "SLO","RLA","SRE","RRA","SAX","LAX","DCP","ISC","XYZ","LD","LDAA","A"
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    mos6502_line_assembler_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_ch(i_ch),
        .i_last(i_last), .i_pc(i_pc), .i_room(i_room), .empty(empty), .pop(pop),
        .o_status(o_status), .o_length(o_length), .o_byte0(o_byte0), .o_byte1(o_byte1),
        .o_byte2(o_byte2)
    );

    mos6502_line_assembler_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_ch(i_ch),
        .i_last(i_last), .i_pc(i_pc), .i_room(i_room), .empty(empty), .pop(pop),
        .o_status(o_status), .o_length(o_length), .o_byte0(o_byte0), .o_byte1(o_byte1),
        .o_byte2(o_byte2), .o_errors(errors), .o_pending(pending)
    );

    function automatic int draw_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Append text, randomly lowering letters.
    function automatic void add_text(input string s);
        byte unsigned c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c | 8'h20;
            line_chars.push_back(c);
        end
    endfunction

    function automatic void add_blanks(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) line_chars.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
    endfunction

    function automatic string value_text(input logic [31:0] v);
        case ($urandom_range(0, 5))
            0: return $sformatf("%0d", v);
            1: return "99999999999";
            2: return $sformatf("$%0h", v);
            default: return $sformatf("$%0h", v);
        endcase
    endfunction

    task automatic send_char(input byte unsigned c, input bit fin,
                             input logic [15:0] pc_in, input logic [1:0] room_in);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_ch <= c;
        i_last <= fin;
        i_pc <= fin ? pc_in : 16'($urandom_range(0, 65535));
        i_room <= fin ? room_in : 2'($urandom_range(0, 3));
        do @(posedge i_clk); while (full);
        chars_sent++;
    endtask

    task automatic send_line(input logic [15:0] pc_in, input logic [1:0] room_in);
        if (line_chars.size() == 0) line_chars.push_back(8'h20);
        for (int i = 0; i < line_chars.size(); i++)
            send_char(line_chars[i], i == line_chars.size() - 1, pc_in, room_in);
        line_chars.delete();
    endtask

    task automatic directed_line(input string s, input logic [15:0] pc_in,
                                 input logic [1:0] room_in);
        for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
        send_line(pc_in, room_in);
    endtask

    task automatic random_line();
        logic [15:0] pc_r;
        logic [1:0]  room_r;
        logic [31:0] v;
        int          form;
        int          pos;
        string       mn;
        pc_r = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF)
                                         : 16'($urandom);
        room_r = $urandom_range(0, 4) == 0 ? 2'($urandom_range(0, 3)) : 2'd3;
        mn = mnem_pool[$urandom_range(0, mnem_pool.size() - 1)];
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 255);
            1: v = $urandom_range(0, 65535);
            2: v = $urandom;
            default: v = 32'(int'(pc_r) + 2 + $urandom_range(0, 280) - 140);
        endcase
        form = $urandom_range(0, 11);
        if (form == 11) begin
            // noise: arbitrary bytes
            repeat ($urandom_range(1, 8)) line_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_blanks(0, 2);
            add_text(mn);
            if (form != 0) add_blanks(1, 2);
            case (form)
                1: add_text("A");
                2: add_text({"#", value_text(v)});
                3, 9, 10: add_text(value_text(v));
                4: add_text({value_text(v), ",X"});
                5: add_text({value_text(v), ",Y"});
                6: add_text({"(", value_text(v), ")"});
                7: add_text({"(", value_text(v), ",X)"});
                8: add_text({"(", value_text(v), "),Y"});
                default: ;
            endcase
            add_blanks(0, 2);
            // break the line now and then
            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(0, line_chars.size());
                line_chars.insert(pos, 8'($urandom_range(0, 255)));
            end
        end
        send_line(pc_r, room_r);
    endtask

    initial begin
        int limit_lines;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_line("asl", 16'h1000, 2'd3);
        directed_line(" \t ", 16'h0000, 2'd0);
        directed_line("lda #$FF", 16'hFFFF, 2'd3);
        directed_line("BNE 0", 16'hFFFF, 2'd2);
        directed_line("stx 1,x", 16'h0000, 2'd3);
        directed_line("nop", 16'h0000, 2'd0);
        directed_line({"J", 8'h00, "P"}, 16'h0000, 2'd3);
        limit_lines = 0;
        while (chars_sent < 1850) begin
            if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
            random_line();
            limit_lines++;
            if (limit_lines == 60) begin
                push <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
